// File: design/fca_pkg.sv
// ----------------------------------------------------------------------------
// fca_pkg
// Shared constants, codes and command structs of the frame cache allocator.
// ----------------------------------------------------------------------------
package fca_pkg;

    localparam int MAX_CPUS   = 8;
    localparam int CACHE_SIZE = 32;
    localparam int BATCH      = 16;
    localparam int RING_DEPTH = 1024;

    localparam int ID_W    = 10;
    localparam int LEN_W   = 16;
    localparam int FC_W    = 11;
    localparam int CPUID_W = 4;
    localparam int LVL_W   = 11;
    localparam int CLVL_W  = 6;
    localparam int CFG_W   = 4;
    localparam int CFGD_W  = 16;

    localparam int RING_AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int RING_CW = $clog2(RING_DEPTH + 1);
    localparam int CPU_W   = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
    localparam int CA_W    = $clog2(MAX_CPUS * CACHE_SIZE);
    localparam int CF_W    = $clog2(CACHE_SIZE + 1);
    localparam int CNT_W   = $clog2(BATCH + 1);
    localparam int REFILL_LIM = (BATCH < CACHE_SIZE) ? BATCH : CACHE_SIZE;
    localparam int RELOAD_MAX = (RING_DEPTH < 1024) ? RING_DEPTH : 1024;

    localparam logic [CFG_W-1:0] CFG_FRAME_COUNT = 4'd0;
    localparam logic [CFG_W-1:0] CFG_FRAME_CAP   = 4'd1;
    localparam logic [LEN_W-1:0] CAP_RESET       = 16'd2048;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_SETUP = 3'd1,
        ST_OVERSIZE  = 3'd2,
        ST_BAD_CPU   = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    typedef struct packed {
        logic                pop;
        logic                push;
        logic [ID_W-1:0]     push_id;
        logic                reload;
        logic [RING_CW-1:0]  reload_n;
    } t_ring_cmd;

    typedef struct packed {
        logic                busy;
        logic [RING_CW-1:0]  fill;
    } t_ring_stat;

    typedef struct packed {
        logic [CPU_W-1:0]    cpu;
        logic                rd;
        logic [CA_W-1:0]     rd_addr;
        logic                wr;
        logic [CA_W-1:0]     wr_addr;
        logic [ID_W-1:0]     wr_data;
        logic                set_fill;
        logic [CF_W-1:0]     fill_val;
        logic                clear;
    } t_cache_cmd;

endpackage

// File: design/fca_ring.sv
// ----------------------------------------------------------------------------
// fca_ring
// Shared FIFO ring of free frame ids: one synchronous memory, head/tail/fill,
// and an initialisation sweep writing id i to entry i after reset or reload.
// ----------------------------------------------------------------------------
module fca_ring (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fca_pkg::t_ring_cmd            i_cmd,
    output fca_pkg::t_ring_stat           o_stat,
    output logic [fca_pkg::ID_W-1:0]      o_rd_data
);

    logic [fca_pkg::ID_W-1:0]    r_mem [fca_pkg::RING_DEPTH];
    logic [fca_pkg::ID_W-1:0]    r_rd_data;
    logic [fca_pkg::RING_AW-1:0] r_head;
    logic [fca_pkg::RING_AW-1:0] r_tail;
    logic [fca_pkg::RING_CW-1:0] r_fill;
    logic                        r_sw_act;
    logic [fca_pkg::RING_AW-1:0] r_sw_addr;
    logic [fca_pkg::RING_AW-1:0] n_reload_tail;

    function automatic logic [fca_pkg::RING_AW-1:0] ptr_inc(
        input logic [fca_pkg::RING_AW-1:0] p);
        if (p == fca_pkg::RING_AW'(fca_pkg::RING_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_comb begin
        if (32'(i_cmd.reload_n) >= fca_pkg::RING_DEPTH) begin
            n_reload_tail = '0;
        end else begin
            n_reload_tail = fca_pkg::RING_AW'(i_cmd.reload_n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sw_act) begin
            r_mem[r_sw_addr] <= fca_pkg::ID_W'(r_sw_addr);
        end else if (i_cmd.push) begin
            r_mem[r_tail] <= i_cmd.push_id;
        end
        if (i_cmd.pop) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_fill    <= '0;
            r_sw_act  <= 1'b1;
            r_sw_addr <= '0;
        end else if (i_cmd.reload) begin
            r_head    <= '0;
            r_tail    <= n_reload_tail;
            r_fill    <= i_cmd.reload_n;
            r_sw_act  <= 1'b1;
            r_sw_addr <= '0;
        end else begin
            if (r_sw_act) begin
                r_sw_addr <= ptr_inc(r_sw_addr);
                if (r_sw_addr == fca_pkg::RING_AW'(fca_pkg::RING_DEPTH - 1)) begin
                    r_sw_act <= 1'b0;
                end
            end
            if (i_cmd.pop) begin
                r_head <= ptr_inc(r_head);
                r_fill <= r_fill - 1'b1;
            end else if (i_cmd.push) begin
                r_tail <= ptr_inc(r_tail);
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    assign o_stat.busy = r_sw_act;
    assign o_stat.fill = r_fill;
    assign o_rd_data   = r_rd_data;

endmodule

// File: design/fca_cache.sv
// ----------------------------------------------------------------------------
// fca_cache
// Per-CPU LIFO caches: one synchronous id memory and a fill count per CPU.
// ----------------------------------------------------------------------------
module fca_cache (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fca_pkg::t_cache_cmd           i_cmd,
    output logic [fca_pkg::ID_W-1:0]      o_rd_data,
    output logic [fca_pkg::CF_W-1:0]      o_fill
);

    logic [fca_pkg::ID_W-1:0] r_mem [fca_pkg::MAX_CPUS * fca_pkg::CACHE_SIZE];
    logic [fca_pkg::ID_W-1:0] r_rd_data;
    logic [fca_pkg::CF_W-1:0] r_fill [fca_pkg::MAX_CPUS];

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[i_cmd.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < fca_pkg::MAX_CPUS; i++) begin
                r_fill[i] <= '0;
            end
        end else if (i_cmd.set_fill) begin
            r_fill[i_cmd.cpu] <= i_cmd.fill_val;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_fill    = r_fill[i_cmd.cpu];

endmodule

// File: design/per_cpu_frame_cache_allocator.sv
// ----------------------------------------------------------------------------
// per_cpu_frame_cache_allocator
// Every transaction passes S_DEC and S_DONE to the output register; a cache hit
// adds S_HIT, and a refill or flush of m ids adds S_REFILL or S_FLUSH and its end state.
// One transaction at a time: input stalls until the result is registered,
// and the ring/cache move runs one id per cycle.
// Reset and frame_count writes run a ring sweep over all RING_DEPTH entries with
// input and configuration stalled; cache fill counts are cleared.
// ----------------------------------------------------------------------------
module per_cpu_frame_cache_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_req_type,
    input  logic [3:0]                    i_cpu_id,
    input  logic [15:0]                   i_data_len,
    input  logic [9:0]                    i_frame_id,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [2:0]                    o_status,
    output logic [9:0]                    o_granted_id,
    output logic                          o_ring_refilled,
    output logic                          o_ring_flushed,
    output logic [10:0]                   o_ring_level,
    output logic [5:0]                    o_cache_level,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fca_pkg::CFG_W-1:0]     i_cfg_index,
    input  logic [fca_pkg::CFGD_W-1:0]    i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_DEC, S_REFILL, S_REFILL_END, S_HIT, S_FLUSH, S_FLUSH_END, S_DONE
    } t_state;

    t_state                          r_state;
    logic [fca_pkg::FC_W-1:0]        r_frame_count;
    logic [fca_pkg::LEN_W-1:0]       r_cap;
    logic                            r_req;
    logic [fca_pkg::CPUID_W-1:0]     r_cpu;
    logic [fca_pkg::LEN_W-1:0]       r_len;
    logic [fca_pkg::ID_W-1:0]        r_fid;
    logic [fca_pkg::CNT_W-1:0]       r_m;
    logic [fca_pkg::CNT_W-1:0]       r_k;
    logic                            r_wr_pend;
    logic [fca_pkg::CNT_W-1:0]       r_wr_idx;
    logic                            r_push_pend;
    fca_pkg::t_status                r_status;
    logic [fca_pkg::ID_W-1:0]        r_granted;
    logic                            r_refilled;
    logic                            r_flushed;
    logic                            r_out_valid;
    fca_pkg::t_status                r_o_status;
    logic [fca_pkg::ID_W-1:0]        r_o_granted;
    logic                            r_o_refilled;
    logic                            r_o_flushed;
    logic [fca_pkg::LVL_W-1:0]       r_o_ring_level;
    logic [fca_pkg::CLVL_W-1:0]      r_o_cache_level;

    fca_pkg::t_ring_cmd              ring_cmd;
    fca_pkg::t_ring_stat             ring_stat;
    logic [fca_pkg::ID_W-1:0]        ring_rd;
    fca_pkg::t_cache_cmd             cache_cmd;
    logic [fca_pkg::ID_W-1:0]        cache_rd;
    logic [fca_pkg::CF_W-1:0]        cfill;

    logic                            in_acc;
    logic                            cfg_acc;
    logic                            has_cache;
    logic                            alloc_ok;
    logic                            ring_full;
    logic [fca_pkg::CA_W-1:0]        base;
    logic [31:0]                     rfill32;
    logic [31:0]                     cfill32;
    logic [31:0]                     room32;
    logic [31:0]                     m_ref32;
    logic [31:0]                     m_fl32;
    logic [31:0]                     reload32;
    logic [31:0]                     clevel32;

    fca_ring u_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (ring_cmd),
        .o_stat   (ring_stat),
        .o_rd_data(ring_rd)
    );

    fca_cache u_cache (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cache_cmd),
        .o_rd_data(cache_rd),
        .o_fill   (cfill)
    );

    assign o_in_stall  = !(r_state == S_IDLE && !ring_stat.busy);
    assign o_cfg_ready = (r_state == S_IDLE) && !ring_stat.busy;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    always_comb begin
        has_cache = 32'(r_cpu) < fca_pkg::MAX_CPUS;
        alloc_ok  = (r_frame_count != '0) && (r_len <= r_cap) && has_cache;
        base      = fca_pkg::CA_W'(32'(r_cpu[fca_pkg::CPU_W-1:0]) * fca_pkg::CACHE_SIZE);
        rfill32   = 32'(ring_stat.fill);
        cfill32   = 32'(cfill);
        ring_full = rfill32 >= fca_pkg::RING_DEPTH;
        room32    = fca_pkg::RING_DEPTH - rfill32;
        m_ref32   = (rfill32 < fca_pkg::REFILL_LIM) ? rfill32 : fca_pkg::REFILL_LIM;
        m_fl32    = (cfill32 < fca_pkg::BATCH) ? cfill32 : fca_pkg::BATCH;
        if (room32 < m_fl32) begin
            m_fl32 = room32;
        end
        reload32  = 32'(i_cfg_data[fca_pkg::FC_W-1:0]);
        if (reload32 > fca_pkg::RELOAD_MAX) begin
            reload32 = fca_pkg::RELOAD_MAX;
        end
        clevel32  = has_cache ? cfill32 : 32'd0;
    end

    always_comb begin
        ring_cmd          = '0;
        ring_cmd.pop      = (r_state == S_REFILL);
        ring_cmd.push     = r_push_pend ||
                            (r_state == S_DEC && r_req == fca_pkg::REQ_RELEASE &&
                             !has_cache && !ring_full);
        ring_cmd.push_id  = r_push_pend ? cache_rd : r_fid;
        ring_cmd.reload   = cfg_acc && (i_cfg_index == fca_pkg::CFG_FRAME_COUNT);
        ring_cmd.reload_n = fca_pkg::RING_CW'(reload32);

        cache_cmd         = '0;
        cache_cmd.cpu     = r_cpu[fca_pkg::CPU_W-1:0];
        cache_cmd.clear   = ring_cmd.reload;
        if (r_state == S_FLUSH) begin
            cache_cmd.rd      = 1'b1;
            cache_cmd.rd_addr = base + fca_pkg::CA_W'(cfill) - fca_pkg::CA_W'(r_k) - 1'b1;
        end else if (r_state == S_DEC && r_req == fca_pkg::REQ_ALLOC && alloc_ok &&
                     cfill != '0) begin
            cache_cmd.rd       = 1'b1;
            cache_cmd.rd_addr  = base + fca_pkg::CA_W'(cfill) - 1'b1;
            cache_cmd.set_fill = 1'b1;
            cache_cmd.fill_val = cfill - 1'b1;
        end
        if (r_wr_pend) begin
            cache_cmd.wr      = 1'b1;
            cache_cmd.wr_addr = base + fca_pkg::CA_W'(r_wr_idx);
            cache_cmd.wr_data = ring_rd;
        end else if (r_state == S_DEC && r_req == fca_pkg::REQ_RELEASE && has_cache &&
                     cfill32 < fca_pkg::CACHE_SIZE) begin
            cache_cmd.wr       = 1'b1;
            cache_cmd.wr_addr  = base + fca_pkg::CA_W'(cfill);
            cache_cmd.wr_data  = r_fid;
            cache_cmd.set_fill = 1'b1;
            cache_cmd.fill_val = cfill + 1'b1;
        end else if (r_state == S_FLUSH_END) begin
            cache_cmd.wr       = 1'b1;
            cache_cmd.wr_addr  = base + fca_pkg::CA_W'(cfill) - fca_pkg::CA_W'(r_m);
            cache_cmd.wr_data  = r_fid;
            cache_cmd.set_fill = 1'b1;
            cache_cmd.fill_val = cfill - fca_pkg::CF_W'(r_m) + 1'b1;
        end
        if (r_state == S_REFILL_END) begin
            cache_cmd.set_fill = 1'b1;
            cache_cmd.fill_val = fca_pkg::CF_W'(r_m) - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_frame_count <= '0;
            r_cap         <= fca_pkg::CAP_RESET;
            r_wr_pend     <= 1'b0;
            r_push_pend   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_wr_pend   <= (r_state == S_REFILL);
            r_wr_idx    <= r_k;
            r_push_pend <= (r_state == S_FLUSH);
            if (cfg_acc) begin
                case (i_cfg_index)
                    fca_pkg::CFG_FRAME_COUNT: r_frame_count <= i_cfg_data[fca_pkg::FC_W-1:0];
                    fca_pkg::CFG_FRAME_CAP:   r_cap         <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_req      <= i_req_type;
                        r_cpu      <= i_cpu_id;
                        r_len      <= i_data_len;
                        r_fid      <= i_frame_id;
                        r_status   <= fca_pkg::ST_OK;
                        r_granted  <= '0;
                        r_refilled <= 1'b0;
                        r_flushed  <= 1'b0;
                        r_state    <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_k <= '0;
                    if (r_req == fca_pkg::REQ_ALLOC) begin
                        if (r_frame_count == '0) begin
                            r_status <= fca_pkg::ST_NOT_SETUP;
                            r_state  <= S_DONE;
                        end else if (r_len > r_cap) begin
                            r_status <= fca_pkg::ST_OVERSIZE;
                            r_state  <= S_DONE;
                        end else if (!has_cache) begin
                            r_status <= fca_pkg::ST_BAD_CPU;
                            r_state  <= S_DONE;
                        end else if (cfill == '0) begin
                            if (m_ref32 == 32'd0) begin
                                r_status <= fca_pkg::ST_EMPTY;
                                r_state  <= S_DONE;
                            end else begin
                                r_m     <= fca_pkg::CNT_W'(m_ref32);
                                r_state <= S_REFILL;
                            end
                        end else begin
                            r_state <= S_HIT;
                        end
                    end else begin
                        if (has_cache && cfill32 >= fca_pkg::CACHE_SIZE) begin
                            r_flushed <= 1'b1;
                            if (m_fl32 == 32'd0) begin
                                r_state <= S_DONE;
                            end else begin
                                r_m     <= fca_pkg::CNT_W'(m_fl32);
                                r_state <= S_FLUSH;
                            end
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_REFILL: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == r_m - 1'b1) begin
                        r_state <= S_REFILL_END;
                    end
                end
                S_REFILL_END: begin
                    r_granted  <= ring_rd;
                    r_refilled <= 1'b1;
                    r_state    <= S_DONE;
                end
                S_HIT: begin
                    r_granted <= cache_rd;
                    r_state   <= S_DONE;
                end
                S_FLUSH: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == r_m - 1'b1) begin
                        r_state <= S_FLUSH_END;
                    end
                end
                S_FLUSH_END: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid     <= 1'b1;
                        r_o_status      <= r_status;
                        r_o_granted     <= r_granted;
                        r_o_refilled    <= r_refilled;
                        r_o_flushed     <= r_flushed;
                        r_o_ring_level  <= (rfill32 > 32'd2047) ? 11'h7FF
                                                                : rfill32[10:0];
                        r_o_cache_level <= (clevel32 > 32'd63) ? 6'h3F
                                                               : clevel32[5:0];
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_granted_id    = r_o_granted;
    assign o_ring_refilled = r_o_refilled;
    assign o_ring_flushed  = r_o_flushed;
    assign o_ring_level    = r_o_ring_level;
    assign o_cache_level   = r_o_cache_level;

endmodule

// File: design/fca_chk.sv
// ----------------------------------------------------------------------------
// fca_chk
// Port-level checks of the frame cache allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fca_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_status,
    input logic [9:0]  o_granted_id,
    input logic        o_ring_refilled,
    input logic        o_ring_flushed,
    input logic [5:0]  o_cache_level
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_granted_id))
        else $error("result dropped while stalled");

    a_fail_no_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != fca_pkg::ST_OK |-> o_granted_id == '0)
        else $error("id granted on a failed transaction");

    a_refill_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_ring_refilled |-> o_status == fca_pkg::ST_OK && !o_ring_flushed)
        else $error("refill reported on a failed transaction");

    a_flush_rel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_ring_flushed |-> o_status == fca_pkg::ST_OK && o_granted_id == '0)
        else $error("flush reported with a grant");

    a_cache_lvl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_cache_level) <= fca_pkg::CACHE_SIZE)
        else $error("cache level above capacity");

endmodule

bind per_cpu_frame_cache_allocator fca_chk u_fca_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_granted_id   (o_granted_id),
    .o_ring_refilled(o_ring_refilled),
    .o_ring_flushed (o_ring_flushed),
    .o_cache_level  (o_cache_level)
);

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// Frame cache allocator testbench
// Drives allocate and release transactions through the valid/stall channels,
// predicts every result with a behavioural model of the shared ring and the
// per-CPU caches, and compares each result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic                         i_req_type;
    logic [3:0]                   i_cpu_id;
    logic [15:0]                  i_data_len;
    logic [9:0]                   i_frame_id;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic [2:0]                   o_status;
    logic [9:0]                   o_granted_id;
    logic                         o_ring_refilled;
    logic                         o_ring_flushed;
    logic [10:0]                  o_ring_level;
    logic [5:0]                   o_cache_level;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [fca_pkg::CFG_W-1:0]    i_cfg_index;
    logic [fca_pkg::CFGD_W-1:0]   i_cfg_data;

    per_cpu_frame_cache_allocator uut (.*);

    typedef struct packed {
        fca_pkg::t_status status;
        logic [9:0]       granted_id;
        logic             refilled;
        logic             flushed;
        logic [10:0]      ring_level;
        logic [5:0]       cache_level;
    } t_grant;

    t_grant      grants_due[$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_idle_pct;

    logic [10:0] pool_frames;
    logic [15:0] pool_cap;
    logic [9:0]  free_ring[fca_pkg::RING_DEPTH];
    int          free_head;
    int          free_fill;
    logic [9:0]  cpu_stack[fca_pkg::MAX_CPUS][fca_pkg::CACHE_SIZE];
    int          stack_fill[fca_pkg::MAX_CPUS];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic bit ring_put(logic [9:0] id);
        if (free_fill >= fca_pkg::RING_DEPTH) return 1'b0;
        free_ring[(free_head + free_fill) % fca_pkg::RING_DEPTH] = id;
        free_fill++;
        return 1'b1;
    endfunction

    function automatic void reload_pool(logic [10:0] n);
        int cnt;
        cnt = (int'(n) > fca_pkg::RING_DEPTH) ? fca_pkg::RING_DEPTH : int'(n);
        for (int i = 0; i < cnt; i++) free_ring[i] = i[9:0];
        free_head = 0;
        free_fill = cnt;
        for (int c = 0; c < fca_pkg::MAX_CPUS; c++) stack_fill[c] = 0;
    endfunction

    function automatic t_grant predict_grant(logic rt, logic [3:0] cpu,
                                             logic [15:0] len, logic [9:0] fid);
        t_grant g;
        g = '0;
        g.status = fca_pkg::ST_OK;
        if (rt == fca_pkg::REQ_ALLOC) begin
            if (pool_frames == 0) g.status = fca_pkg::ST_NOT_SETUP;
            else if (len > pool_cap) g.status = fca_pkg::ST_OVERSIZE;
            else if (cpu >= fca_pkg::MAX_CPUS) g.status = fca_pkg::ST_BAD_CPU;
            else begin
                if (stack_fill[cpu] == 0) begin
                    for (int i = 0; i < fca_pkg::REFILL_LIM && free_fill > 0; i++) begin
                        cpu_stack[cpu][stack_fill[cpu]] = free_ring[free_head];
                        free_head = (free_head + 1) % fca_pkg::RING_DEPTH;
                        free_fill--;
                        stack_fill[cpu]++;
                    end
                    g.refilled = stack_fill[cpu] != 0;
                end
                if (stack_fill[cpu] != 0) begin
                    stack_fill[cpu]--;
                    g.granted_id = cpu_stack[cpu][stack_fill[cpu]];
                end else begin
                    g.status = fca_pkg::ST_EMPTY;
                end
            end
        end else if (cpu >= fca_pkg::MAX_CPUS) begin
            void'(ring_put(fid));
        end else begin
            if (stack_fill[cpu] >= fca_pkg::CACHE_SIZE) begin
                g.flushed = 1'b1;
                for (int i = 0; i < fca_pkg::BATCH && stack_fill[cpu] > 0; i++) begin
                    if (!ring_put(cpu_stack[cpu][stack_fill[cpu] - 1])) break;
                    stack_fill[cpu]--;
                end
            end
            if (stack_fill[cpu] < fca_pkg::CACHE_SIZE) begin
                cpu_stack[cpu][stack_fill[cpu]] = fid;
                stack_fill[cpu]++;
            end else begin
                void'(ring_put(fid));
            end
        end
        g.ring_level = 11'(free_fill);
        g.cache_level = (cpu < fca_pkg::MAX_CPUS) ? 6'(stack_fill[cpu]) : 6'd0;
        return g;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_grant w;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (grants_due.size() == 0) begin
                    report_mismatch("unexpected transaction", 1, 0);
                end else begin
                    w = grants_due.pop_front();
                    if (o_status != w.status)
                        report_mismatch("status", int'(o_status), int'(w.status));
                    if (o_granted_id != w.granted_id)
                        report_mismatch("granted_id", int'(o_granted_id),
                                        int'(w.granted_id));
                    if (o_ring_refilled != w.refilled)
                        report_mismatch("ring_refilled", int'(o_ring_refilled),
                                        int'(w.refilled));
                    if (o_ring_flushed != w.flushed)
                        report_mismatch("ring_flushed", int'(o_ring_flushed),
                                        int'(w.flushed));
                    if (o_ring_level != w.ring_level)
                        report_mismatch("ring_level", int'(o_ring_level),
                                        int'(w.ring_level));
                    if (o_cache_level != w.cache_level)
                        report_mismatch("cache_level", int'(o_cache_level),
                                        int'(w.cache_level));
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic send_request(logic rt, logic [3:0] cpu, logic [15:0] len,
                                logic [9:0] fid);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_req_type <= rt;
        i_cpu_id   <= cpu;
        i_data_len <= len;
        i_frame_id <= fid;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        grants_due.push_back(predict_grant(rt, cpu, len, fid));
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain;
        while (grants_due.size() != 0) @(posedge i_clk);
        repeat (fca_pkg::BATCH + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [fca_pkg::CFG_W-1:0] idx, logic [15:0] val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == fca_pkg::CFG_FRAME_COUNT) begin
            pool_frames = val[10:0];
            reload_pool(val[10:0]);
        end else if (idx == fca_pkg::CFG_FRAME_CAP) begin
            pool_cap = val;
        end
    endtask

    task automatic test_not_set_up;
        send_request(fca_pkg::REQ_ALLOC, 4'd0, 16'd0, 10'd0);
        send_request(fca_pkg::REQ_RELEASE, 4'd15, 16'hFFFF, 10'h3FF);
        send_request(fca_pkg::REQ_RELEASE, 4'd2, 16'd0, 10'd5);
        send_request(fca_pkg::REQ_ALLOC, 4'd2, 16'd0, 10'd0);
    endtask

    task automatic test_directed;
        write_reg(fca_pkg::CFG_FRAME_COUNT, 16'd20);
        write_reg(fca_pkg::CFG_FRAME_CAP, 16'd100);
        send_request(fca_pkg::REQ_ALLOC, 4'd0, 16'd101, 10'd0);
        send_request(fca_pkg::REQ_ALLOC, 4'd8, 16'd100, 10'd0);
        send_request(fca_pkg::REQ_ALLOC, 4'd15, 16'd0, 10'd0);
        send_request(fca_pkg::REQ_ALLOC, 4'd0, 16'd100, 10'd0);
        send_request(fca_pkg::REQ_ALLOC, 4'd1, 16'd0, 10'd0);
        send_request(fca_pkg::REQ_ALLOC, 4'd2, 16'd0, 10'd0);
        send_request(fca_pkg::REQ_ALLOC, 4'd7, 16'd0, 10'd0);
        send_request(fca_pkg::REQ_RELEASE, 4'd0, 16'd0, 10'h3FF);
        send_request(fca_pkg::REQ_ALLOC, 4'd0, 16'd0, 10'd0);
        for (int i = 0; i < 3; i++)
            send_request(fca_pkg::REQ_RELEASE, 4'd9, 16'd0, i[9:0]);
        write_reg(fca_pkg::CFG_FRAME_CAP, 16'hFFFF);
        send_request(fca_pkg::REQ_ALLOC, 4'd3, 16'hFFFF, 10'd0);
        write_reg(4'd9, 16'd0);
        write_reg(fca_pkg::CFG_FRAME_CAP, 16'd0);
        send_request(fca_pkg::REQ_ALLOC, 4'd3, 16'd1, 10'd0);
    endtask

    // Full-cache release against a full ring: the flush finds no room.
    task automatic test_ring_full;
        write_reg(fca_pkg::CFG_FRAME_COUNT, 16'd1024);
        write_reg(fca_pkg::CFG_FRAME_CAP, 16'd2048);
        for (int i = 0; i < 34; i++)
            send_request(fca_pkg::REQ_RELEASE, 4'd4, 16'd0, 10'($urandom_range(1023)));
        send_request(fca_pkg::REQ_RELEASE, 4'd12, 16'd0, 10'd1);
        write_reg(fca_pkg::CFG_FRAME_COUNT, 16'h7FF);
        send_request(fca_pkg::REQ_ALLOC, 4'd5, 16'd0, 10'd0);
    endtask

    task automatic test_random(int n);
        int r;
        for (int k = 0; k < n; k++) begin
            if (k % 120 == 60)
                write_reg(fca_pkg::CFG_FRAME_COUNT, 16'($urandom_range(40, 1)));
            if (k % 150 == 75)
                write_reg(fca_pkg::CFG_FRAME_CAP, 16'($urandom_range(4096, 1024)));
            if (k == 100) write_reg(fca_pkg::CFG_FRAME_COUNT, 16'd1024);
            r = $urandom_range(99);
            if (r < 48)
                send_request(fca_pkg::REQ_ALLOC, 4'($urandom_range(9)),
                             16'($urandom_range(r < 2 ? 16'hFFFF : 1024)), 10'd0);
            else if (r < 95)
                send_request(fca_pkg::REQ_RELEASE, 4'($urandom_range(9)),
                             16'($urandom), 10'($urandom));
            else
                send_request(1'($urandom), 4'($urandom), 16'($urandom), 10'($urandom));
        end
    endtask

    initial begin
        mismatches = 0;
        send_idle_pct = 18;
        recv_idle_pct = 80;
        pool_frames = 0;
        pool_cap = fca_pkg::CAP_RESET;
        for (int i = 0; i < fca_pkg::RING_DEPTH; i++) free_ring[i] = i[9:0];
        free_head = 0;
        free_fill = 0;
        for (int c = 0; c < fca_pkg::MAX_CPUS; c++) stack_fill[c] = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        i_req_type = 1'b0;
        i_cpu_id = '0;
        i_data_len = '0;
        i_frame_id = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_not_set_up();
        test_directed();
        test_ring_full();
        test_random(170);
        drain();
        send_idle_pct = 80;
        recv_idle_pct = 18;
        test_random(170);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(170);
        drain();

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// File: filelist.f
design/fca_pkg.sv
design/fca_ring.sv
design/fca_cache.sv
design/per_cpu_frame_cache_allocator.sv
design/fca_chk.sv
bench/testbench.sv
